// ===== rtl/core/smqs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smqs_pkg
// Shared types for the sorted matrix quadrant search block: the search
// sequencer states.
// ----------------------------------------------------------------------------
package smqs_pkg;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POP,
		S_LOAD,
		S_CELL,
		S_FIRST,
		S_LAST,
		S_MID,
		S_PUSH,
		S_DONE
	} smqs_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/sorted_matrix_quadrant_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_matrix_quadrant_search
// Matrix store with a quadrant divide-and-conquer key search driven by a
// region stack; both the matrix and the stack sit in single-port memories.
// Timing: a write item gives no result. A search item walks the visited regions;
// each takes a pop, a stack read, three serial reads of the matrix port and a
// second push, and may stop early; the matrix read port sets the pace.
// Throughput: one item at a time; the next item is taken once the sequencer
// returns to idle, while a result may still wait in the output register.
// Reset clears the sequencer, stack pointer and output valid; matrix contents
// stay undefined until written.
// ----------------------------------------------------------------------------
module sorted_matrix_quadrant_search #(
	parameter int ROWS        = 4,
	parameter int COLS        = 4,
	parameter int STACK_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               op,
	input  wire logic [1:0]         row,
	input  wire logic [1:0]         col,
	input  wire logic signed [31:0] value,
	input  wire logic signed [31:0] search_key,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    found,
	output logic [1:0]              found_row,
	output logic [1:0]              found_col
);
	import smqs_pkg::*;

	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int CELLS = ROWS * COLS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int SPW   = $clog2(STACK_DEPTH + 1);
	localparam int SIW   = $clog2(STACK_DEPTH);

	typedef struct packed {
		logic [RW-1:0] r0;
		logic [RW-1:0] r1;
		logic [CW-1:0] c0;
		logic [CW-1:0] c1;
	} region_t;

	smqs_state_t state_q, state_d;

	logic signed [31:0] mat_mem [CELLS];
	logic signed [31:0] mat_rd_s1;
	region_t            stk_mem [STACK_DEPTH];
	region_t            stk_rd_s1;

	logic [SPW-1:0]     sp_q;
	logic [SPW-1:0]     sp_dec;
	logic signed [31:0] key_q;
	region_t            rg_q;
	region_t            pend_q;
	logic               pend_ok_q;
	logic               hit_q;
	logic [1:0]         hrow_q;
	logic [1:0]         hcol_q;
	logic               out_valid_q;
	logic               found_q;
	logic [1:0]         found_row_q;
	logic [1:0]         found_col_q;

	logic               mat_re;
	logic [AW-1:0]      mat_raddr;
	logic               mat_we;
	logic [AW-1:0]      mat_waddr;
	logic               stk_re;
	logic               stk_we;
	logic [SIW-1:0]     stk_waddr;
	region_t            stk_wdata;

	logic               acc;
	logic               wr_in_range;
	logic [RW:0]        rsum;
	logic [CW:0]        csum;
	logic [RW-1:0]      mr;
	logic [CW-1:0]      mc;
	logic               key_gt_mid;
	region_t            reg_a;
	region_t            reg_b;
	logic               ok_a;
	logic               ok_b;
	logic               sp_room;
	logic               out_free;
	region_t            full_region;

	assign acc         = in_valid && in_ready;
	assign sp_dec      = sp_q - SPW'(1);
	assign sp_room     = sp_q < SPW'(STACK_DEPTH);
	assign out_free    = !out_valid_q || out_ready;
	assign wr_in_range = (7'(row) < 7'(ROWS)) && (7'(col) < 7'(COLS));
	assign mat_waddr   = AW'(RW'(row)) * AW'(COLS) + AW'(CW'(col));

	assign full_region.r0 = '0;
	assign full_region.r1 = RW'(ROWS - 1);
	assign full_region.c0 = '0;
	assign full_region.c1 = CW'(COLS - 1);

	// midpoint of the current region and the two subregions
	assign rsum       = {1'b0, rg_q.r0} + {1'b0, rg_q.r1};
	assign csum       = {1'b0, rg_q.c0} + {1'b0, rg_q.c1};
	assign mr         = rsum[RW:1];
	assign mc         = csum[CW:1];
	assign key_gt_mid = key_q > mat_rd_s1;

	always_comb begin
		if (key_gt_mid) begin
			reg_a = '{r0: mr + RW'(1), r1: rg_q.r1, c0: rg_q.c0, c1: rg_q.c1};
			ok_a  = mr != rg_q.r1;
			reg_b = '{r0: rg_q.r0, r1: mr, c0: mc + CW'(1), c1: rg_q.c1};
			ok_b  = mc != rg_q.c1;
		end else begin
			reg_a = '{r0: rg_q.r0, r1: rg_q.r1, c0: rg_q.c0, c1: mc - CW'(1)};
			ok_a  = mc != rg_q.c0;
			reg_b = '{r0: rg_q.r0, r1: mr - RW'(1), c0: mc, c1: rg_q.c1};
			ok_b  = mr != rg_q.r0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && op) state_d = S_POP;
			end
			S_POP: begin
				state_d = (sp_q == '0) ? S_DONE : S_LOAD;
			end
			S_LOAD: begin
				if (stk_rd_s1.r0 == stk_rd_s1.r1 && stk_rd_s1.c0 == stk_rd_s1.c1)
					state_d = S_CELL;
				else
					state_d = S_FIRST;
			end
			S_CELL: begin
				state_d = (mat_rd_s1 == key_q) ? S_DONE : S_POP;
			end
			S_FIRST: begin
				state_d = (mat_rd_s1 > key_q) ? S_POP : S_LAST;
			end
			S_LAST: begin
				state_d = (mat_rd_s1 < key_q) ? S_POP : S_MID;
			end
			S_MID: begin
				state_d = (mat_rd_s1 == key_q) ? S_DONE : S_PUSH;
			end
			S_PUSH: begin
				state_d = S_POP;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory and handshake controls
	always_comb begin
		in_ready  = 1'b0;
		mat_re    = 1'b0;
		mat_raddr = '0;
		mat_we    = 1'b0;
		stk_re    = 1'b0;
		stk_we    = 1'b0;
		stk_waddr = sp_q[SIW-1:0];
		stk_wdata = full_region;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				mat_we    = acc && !op && wr_in_range;
				stk_we    = acc && op;
				stk_waddr = '0;
			end
			S_POP: begin
				stk_re = sp_q != '0;
			end
			S_LOAD: begin
				mat_re    = 1'b1;
				mat_raddr = AW'(stk_rd_s1.r0) * AW'(COLS) + AW'(stk_rd_s1.c0);
			end
			S_FIRST: begin
				mat_re    = 1'b1;
				mat_raddr = AW'(rg_q.r1) * AW'(COLS) + AW'(rg_q.c1);
			end
			S_LAST: begin
				mat_re    = 1'b1;
				mat_raddr = AW'(mr) * AW'(COLS) + AW'(mc);
			end
			S_MID: begin
				stk_we    = (mat_rd_s1 != key_q) && ok_a && sp_room;
				stk_wdata = reg_a;
			end
			S_PUSH: begin
				stk_we    = pend_ok_q && sp_room;
				stk_wdata = pend_q;
			end
			S_CELL, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// matrix memory
	always_ff @(posedge clk) begin
		if (mat_we) mat_mem[mat_waddr] <= value;
	end

	always_ff @(posedge clk) begin
		if (mat_re) mat_rd_s1 <= mat_mem[mat_raddr];
	end

	// region stack memory
	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
	end

	always_ff @(posedge clk) begin
		if (stk_re) stk_rd_s1 <= stk_mem[sp_dec[SIW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (stk_we) begin
				sp_q <= (state_q == S_IDLE) ? SPW'(1) : sp_q + SPW'(1);
			end else if (stk_re) begin
				sp_q <= sp_dec;
			end else if (state_q == S_DONE) begin
				sp_q <= '0;
			end
			if (acc && op) begin
				hit_q <= 1'b0;
			end else if ((state_q == S_CELL || state_q == S_MID) && mat_rd_s1 == key_q) begin
				hit_q <= 1'b1;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && op) begin
			key_q  <= search_key;
			hrow_q <= '0;
			hcol_q <= '0;
		end
		if (state_q == S_LOAD) rg_q <= stk_rd_s1;
		if (state_q == S_MID) begin
			pend_q    <= reg_b;
			pend_ok_q <= ok_b;
		end
		if (state_q == S_CELL && mat_rd_s1 == key_q) begin
			hrow_q <= 2'(rg_q.r0);
			hcol_q <= 2'(rg_q.c0);
		end
		if (state_q == S_MID && mat_rd_s1 == key_q) begin
			hrow_q <= 2'(mr);
			hcol_q <= 2'(mc);
		end
		if (state_q == S_DONE && out_free) begin
			found_q     <= hit_q;
			found_row_q <= hrow_q;
			found_col_q <= hcol_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign found_row = found_row_q;
	assign found_col = found_col_q;

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result without finished search");

	a_load_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |-> $past(state_q) == S_POP && $past(sp_q) != '0)
		else $error("region load without pop");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> found_row_q == '0 && found_col_q == '0)
		else $error("miss with nonzero cell");

	a_region_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIRST |-> rg_q.r1 <= RW'(ROWS - 1) && rg_q.c1 <= CW'(COLS - 1))
		else $error("region outside matrix");

endmodule
`default_nettype wire

// ===== bench/smqs_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smqs_tb_pkg
// Operation codes, matrix size and the search result shape shared by the
// quadrant search bench top and its checker.
// ----------------------------------------------------------------------------
package smqs_tb_pkg;

	localparam int GRID_ROWS          = 4;
	localparam int GRID_COLS          = 4;
	localparam int REGION_STACK_DEPTH = 16;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SEARCH = 1'b1
	} smqs_op_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] row_at;
		logic [1:0] col_at;
	} lookup_t;

endpackage

// ===== bench/smqs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smqs_checker
// Watches both channels of the quadrant search block, keeps a shadow copy
// of the matrix, predicts each search outcome and compares every result
// item field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module smqs_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic               op,
	input  wire logic [1:0]         row,
	input  wire logic [1:0]         col,
	input  wire logic signed [31:0] value,
	input  wire logic signed [31:0] search_key,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic               found,
	input  wire logic [1:0]         found_row,
	input  wire logic [1:0]         found_col,
	output int                      errors,
	output int                      outstanding
);
	import smqs_tb_pkg::*;

	typedef struct {
		int r0;
		int r1;
		int c0;
		int c1;
	} span_t;

	logic signed [31:0] grid [GRID_ROWS][GRID_COLS];
	span_t              span_stack [REGION_STACK_DEPTH];
	int                 span_top;
	lookup_t            lookup_q [$];

	initial begin
		errors      = 0;
		outstanding = 0;
		span_top    = 0;
	end

	// empty regions and pushes onto a full stack are dropped
	function automatic void push_span(input int r0, input int r1, input int c0, input int c1);
		if (r0 > r1 || c0 > c1)
			return;
		if (span_top >= REGION_STACK_DEPTH)
			return;
		span_stack[span_top] = '{r0, r1, c0, c1};
		span_top++;
	endfunction

	function automatic lookup_t locate_key(input logic signed [31:0] key);
		lookup_t            res;
		span_t              g;
		int                 mr;
		int                 mc;
		logic signed [31:0] mv;
		res      = '0;
		span_top = 0;
		push_span(0, GRID_ROWS - 1, 0, GRID_COLS - 1);
		while (span_top > 0 && !res.hit) begin
			span_top--;
			g = span_stack[span_top];
			if (g.r0 == g.r1 && g.c0 == g.c1) begin
				if (grid[g.r0][g.c0] == key) begin
					res.hit    = 1'b1;
					res.row_at = g.r0[1:0];
					res.col_at = g.c0[1:0];
				end
			end else if (!(grid[g.r0][g.c0] > key || grid[g.r1][g.c1] < key)) begin
				mr = (g.r0 + g.r1) / 2;
				mc = (g.c0 + g.c1) / 2;
				mv = grid[mr][mc];
				if (mv == key) begin
					res.hit    = 1'b1;
					res.row_at = mr[1:0];
					res.col_at = mc[1:0];
				end else if (key > mv) begin
					push_span(mr + 1, g.r1, g.c0, g.c1);
					push_span(g.r0, mr, mc + 1, g.c1);
				end else begin
					push_span(g.r0, g.r1, g.c0, mc - 1);
					push_span(g.r0, mr - 1, mc, g.c1);
				end
			end
		end
		span_top = 0;
		return res;
	endfunction

	always @(posedge clk) begin
		lookup_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (lookup_q.size() == 0) begin
					errors++;
					$error("result item with no search pending");
				end else begin
					want = lookup_q.pop_front();
					if (found !== want.hit) begin
						errors++;
						$error("found: expected %0d, actual %0d", want.hit, found);
					end
					if (found_row !== want.row_at) begin
						errors++;
						$error("found_row: expected %0d, actual %0d", want.row_at, found_row);
					end
					if (found_col !== want.col_at) begin
						errors++;
						$error("found_col: expected %0d, actual %0d", want.col_at, found_col);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (op == OP_SEARCH)
					lookup_q.push_back(locate_key(search_key));
				else
					grid[row][col] = value;
			end
			outstanding = lookup_q.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the sorted matrix quadrant search block: fills the matrix,
// then mixes sorted refills, partial overwrites and loose traffic with
// searches for present and absent keys, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import smqs_tb_pkg::*;

	localparam int N_ITEMS      = 1600;
	localparam int CALM_AFTER   = 1450;
	localparam int HOLD_AT      = 120;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 200;

	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               op;
	logic [1:0]         row;
	logic [1:0]         col;
	logic signed [31:0] value;
	logic signed [31:0] search_key;
	logic               out_valid;
	logic               out_ready;
	logic               found;
	logic [1:0]         found_row;
	logic [1:0]         found_col;

	int                 errors;
	int                 outstanding;
	int                 items_sent   = 0;
	int                 results_seen = 0;
	logic               calm         = 1'b0;
	logic               held         = 1'b0;
	logic signed [31:0] plan [GRID_ROWS][GRID_COLS];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	sorted_matrix_quadrant_search DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.row        (row),
		.col        (col),
		.value      (value),
		.search_key (search_key),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.found_row  (found_row),
		.found_col  (found_col)
	);

	smqs_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.row         (row),
		.col         (col),
		.value       (value),
		.search_key  (search_key),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.found_row   (found_row),
		.found_col   (found_col),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input smqs_op_t o, input logic [1:0] r, input logic [1:0] c,
			input logic signed [31:0] v, input logic signed [31:0] k);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid   <= 1'b1;
		op         <= o;
		row        <= r;
		col        <= c;
		value      <= v;
		search_key <= k;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
		calm = (items_sent >= CALM_AFTER);
	endtask

	task automatic write_cell(input int r, input int c, input logic signed [31:0] v);
		plan[r][c] = v;
		send_item(OP_WRITE, r[1:0], c[1:0], v, $urandom);
	endtask

	task automatic search_for(input logic signed [31:0] k);
		send_item(OP_SEARCH, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom, k);
	endtask

	function automatic logic signed [31:0] pick_key();
		int sel;
		int r;
		int c;
		sel = $urandom_range(0, 19);
		r   = $urandom_range(0, GRID_ROWS - 1);
		c   = $urandom_range(0, GRID_COLS - 1);
		if (sel < 10)
			return plan[r][c];
		else if (sel < 12)
			return plan[r][c] + 1;
		else if (sel < 14)
			return plan[r][c] - 1;
		else if (sel < 17)
			return $urandom;
		else if (sel == 17)
			return S32_MIN;
		else if (sel == 18)
			return S32_MAX;
		else
			return 0;
	endfunction

	// rows and columns non-decreasing, written in shuffled order
	task automatic fill_sorted();
		longint      acc [GRID_ROWS][GRID_COLS];
		longint      base;
		longint      prev;
		int unsigned step_max;
		int          order [GRID_ROWS * GRID_COLS];
		int          j;
		int          t;
		case ($urandom_range(0, 2))
			0: begin
				step_max = 3;
				base     = longint'($urandom_range(0, 200)) - 100;
			end
			1: begin
				step_max = 1000;
				base     = longint'($signed($urandom));
			end
			default: begin
				step_max = 32'h1000_0000;
				base     = longint'(S32_MIN) + longint'($urandom_range(0, 1000));
			end
		endcase
		for (int r = 0; r < GRID_ROWS; r++) begin
			for (int c = 0; c < GRID_COLS; c++) begin
				prev = base;
				if (r > 0 && acc[r - 1][c] > prev)
					prev = acc[r - 1][c];
				if (c > 0 && acc[r][c - 1] > prev)
					prev = acc[r][c - 1];
				acc[r][c] = prev + longint'($urandom_range(0, step_max));
				if (acc[r][c] > longint'(S32_MAX))
					acc[r][c] = longint'(S32_MAX);
			end
		end
		for (int i = 0; i < GRID_ROWS * GRID_COLS; i++)
			order[i] = i;
		for (int i = GRID_ROWS * GRID_COLS - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			t        = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		foreach (order[i])
			write_cell(order[i] / GRID_COLS, order[i] % GRID_COLS,
				acc[order[i] / GRID_COLS][order[i] % GRID_COLS][31:0]);
	endtask

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			results_seen++;

	// receiver side, with one long hold-off so the block backs up
	initial begin
		@(posedge arst_n);
		forever begin
			if (!held && results_seen >= HOLD_AT) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held = 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall = 0;
			else
				stall++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic signed [31:0] seed_vals [GRID_ROWS * GRID_COLS];
		logic signed [31:0] seed_keys [9];
		int                 kind;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		op         = OP_WRITE;
		row        = '0;
		col        = '0;
		value      = '0;
		search_key = '0;
		out_ready  = 1'b0;
		seed_vals  = '{S32_MIN, -1000, -10, 0,
			-500, -5, 1, 100,
			-1, 2, 150, 1000,
			3, 200, 5000, S32_MAX};
		seed_keys  = '{S32_MIN, S32_MAX, -5, 150, 3, 0, 50, -3, S32_MAX - 1};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every cell is written before the first search
		foreach (seed_vals[i])
			write_cell(i / GRID_COLS, i % GRID_COLS, seed_vals[i]);
		foreach (seed_keys[i])
			search_for(seed_keys[i]);

		while (items_sent < N_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				fill_sorted();
				repeat ($urandom_range(2, 8))
					search_for(pick_key());
			end else if (kind < 8) begin
				// overwrites that may break the ordering
				repeat ($urandom_range(1, 4))
					write_cell($urandom_range(0, GRID_ROWS - 1), $urandom_range(0, GRID_COLS - 1),
						($urandom_range(0, 1) == 0) ? $urandom : pick_key());
				repeat ($urandom_range(1, 6))
					search_for(pick_key());
			end else begin
				repeat ($urandom_range(3, 10)) begin
					if ($urandom_range(0, 1) == 0)
						write_cell($urandom_range(0, GRID_ROWS - 1),
							$urandom_range(0, GRID_COLS - 1), $urandom);
					else
						search_for($urandom);
				end
			end
		end
		in_valid <= 1'b0;

		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/smqs_pkg.sv
rtl/core/sorted_matrix_quadrant_search.sv
bench/smqs_tb_pkg.sv
bench/smqs_checker.sv
bench/tb_top.sv
